// ===== rtl/sec_pkg.sv =====
// Package for the sound envelope classifier: widths, register indexes,
// reset values, class codes and the sequencer state type.
// No dependencies.
package sec_pkg;

  localparam int unsigned CalibWindowsDef = 120;
  localparam int unsigned SampleBitsDef   = 12;

  localparam int unsigned SampleW  = 12;
  localparam int unsigned LevelW   = 16;
  localparam int unsigned ClassW   = 2;
  localparam int unsigned FracW    = 16;
  localparam int unsigned EnvW     = SampleW + FracW;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam int unsigned DivSteps = EnvW + 8;
  localparam int unsigned MulSteps = 16;
  localparam int unsigned LvlSteps = 8;
  localparam int unsigned CountW   = 6;

  localparam logic [CfgAddrW-1:0] CfgWindowLen = 3'd0;
  localparam logic [CfgAddrW-1:0] CfgEnvAlpha  = 3'd1;
  localparam logic [CfgAddrW-1:0] CfgGain      = 3'd2;
  localparam logic [CfgAddrW-1:0] CfgTalkThr   = 3'd3;
  localparam logic [CfgAddrW-1:0] CfgClapThr   = 3'd4;

  localparam logic [4:0]  WindowLenRst = 5'd8;
  localparam logic [15:0] EnvAlphaRst  = 16'd9830;
  localparam logic [7:0]  GainRst      = 8'd12;
  localparam logic [15:0] TalkThrRst   = 16'd2500;
  localparam logic [15:0] ClapThrRst   = 16'd400;

  localparam logic [ClassW-1:0] ClassSilence = 2'd0;
  localparam logic [ClassW-1:0] ClassClap    = 2'd1;
  localparam logic [ClassW-1:0] ClassTalk    = 2'd2;

  typedef enum logic [2:0] {
    StIdle,
    StDiv,
    StMul,
    StEnv,
    StSub,
    StLvl,
    StFin
  } state_e;

endpackage

// ===== rtl/sound_envelope_classifier_core.sv =====
// Sound envelope classifier core: window peak, calibration baseline, envelope
// smoothing and level classes. Uses sec_pkg.
// Non-closing samples and calibration windows are taken while idle; the last calibration
// window runs the bit-serial baseline divider. A result window steps through accept,
// alpha multiply, envelope, excess, gain multiply and output, and stays in output
// while a result waits; reset (async, active low) restores defaults, recalibrates.
module sound_envelope_classifier_core #(
  parameter int unsigned CALIB_WINDOWS = sec_pkg::CalibWindowsDef,
  parameter int unsigned SAMPLE_BITS   = sec_pkg::SampleBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sec_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [sec_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [sec_pkg::SampleW-1:0]   sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sec_pkg::ClassW-1:0]    sound_class_o,
  output logic [sec_pkg::LevelW-1:0]    level_o,
  output logic [sec_pkg::SampleW-1:0]   window_peak_o
);

  localparam int unsigned SW = sec_pkg::SampleW;
  localparam int unsigned EW = sec_pkg::EnvW;
  localparam int unsigned FW = sec_pkg::FracW;
  localparam logic [SW-1:0] SampleMask =
    (SAMPLE_BITS >= SW) ? {SW{1'b1}} : SW'((1 << SAMPLE_BITS) - 1);
  localparam logic [7:0] CalibCnt = 8'(CALIB_WINDOWS);
  localparam logic [8:0] CalibDiv = 9'(CALIB_WINDOWS);
  localparam logic [sec_pkg::CountW-1:0] DivLast = sec_pkg::CountW'(sec_pkg::DivSteps - 1);
  localparam logic [sec_pkg::CountW-1:0] MulLast = sec_pkg::CountW'(sec_pkg::MulSteps - 1);
  localparam logic [sec_pkg::CountW-1:0] LvlLast = sec_pkg::CountW'(sec_pkg::LvlSteps - 1);

  // configuration
  logic [4:0]  wlen_q;
  logic [15:0] alpha_q;
  logic [7:0]  gain_q;
  logic [15:0] talk_q;
  logic [15:0] clap_q;

  // sequencer
  sec_pkg::state_e state_q, state_d;
  logic [sec_pkg::CountW-1:0] count_q, count_d;

  // block state
  logic [SW-1:0]  run_peak_q;
  logic [4:0]     win_cnt_q;
  logic [19:0]    calib_sum_q;
  logic [7:0]     win_calib_q;
  logic           calib_q;
  logic [EW-1:0]  base_q;
  logic [EW-1:0]  env_q;

  // datapath
  logic [EW+7:0]  dq_q, dq_d;
  logic [7:0]     rem_q, rem_d;
  logic [EW:0]    diff_q;
  logic [EW+1:0]  acc_q, acc_d;
  logic [15:0]    alpha_sh_q;
  logic [SW-1:0]  exc_q;
  logic [7:0]     gain_sh_q;
  logic [19:0]    prod_q, prod_d;
  logic [SW-1:0]  peak_q;

  // output register
  logic                       out_valid_q;
  logic [sec_pkg::ClassW-1:0] class_q;
  logic [15:0]                level_q;
  logic [SW-1:0]              opeak_q;

  // FSM outputs
  logic in_ready, in_fire, out_load;

  // accept-cycle logic
  logic [SW-1:0] s_masked, peak_new;
  logic [4:0]    cnt_new, len_eff;
  logic          win_done;
  logic [19:0]   sum_new;
  logic [7:0]    wc_new;
  logic          calib_end;
  logic [EW:0]   diff_new;

  assign s_masked  = sample_i & SampleMask;
  assign peak_new  = (s_masked > run_peak_q) ? s_masked : run_peak_q;
  assign cnt_new   = win_cnt_q + 5'd1;
  assign len_eff   = (wlen_q == 5'd0) ? 5'd1 : wlen_q;
  assign win_done  = (cnt_new >= len_eff);
  assign sum_new   = calib_sum_q + 20'(peak_new);
  assign wc_new    = win_calib_q + 8'd1;
  assign calib_end = (wc_new >= CalibCnt);
  assign diff_new  = {1'b0, peak_new, {FW{1'b0}}} - {1'b0, env_q};

  // restoring divider step
  logic [8:0] trial;
  logic       trial_ge;
  assign trial    = {rem_q, dq_q[EW+7]};
  assign trial_ge = (trial >= CalibDiv);
  assign rem_d    = trial_ge ? 8'(trial - CalibDiv) : trial[7:0];
  assign dq_d     = {dq_q[EW+6:0], trial_ge};

  // alpha multiply step, LSB first, floor shift each step
  logic [EW+2:0] mul_sum;
  assign mul_sum = {acc_q[EW+1], acc_q} +
                   (alpha_sh_q[0] ? {{2{diff_q[EW]}}, diff_q} : '0);
  assign acc_d   = mul_sum[EW+2:1];

  // envelope update and excess
  logic [EW+1:0] env_sum;
  logic [EW-1:0] env_diff;
  assign env_sum  = {2'b00, env_q} + acc_q;
  assign env_diff = env_q - base_q;

  // gain multiply step, MSB first
  assign prod_d = {prod_q[18:0], 1'b0} + (gain_sh_q[7] ? 20'(exc_q) : 20'd0);

  // saturation and class
  logic [15:0]                lvl_sat;
  logic [sec_pkg::ClassW-1:0] cls;
  assign lvl_sat = (|prod_q[19:16]) ? 16'hFFFF : prod_q[15:0];

  always_comb begin
    priority if (lvl_sat > talk_q) begin
      cls = sec_pkg::ClassTalk;
    end else if (lvl_sat > clap_q) begin
      cls = sec_pkg::ClassClap;
    end else begin
      cls = sec_pkg::ClassSilence;
    end
  end

  // FSM outputs
  always_comb begin
    in_ready = (state_q == sec_pkg::StIdle);
    in_fire  = in_ready && in_valid_i;
    out_load = (state_q == sec_pkg::StFin) && (!out_valid_q || out_ready_i);
  end

  // FSM next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sec_pkg::StIdle: begin
        if (in_fire && win_done) begin
          if (!calib_q) begin
            state_d = sec_pkg::StMul;
          end else if (calib_end) begin
            state_d = sec_pkg::StDiv;
          end
        end
      end
      sec_pkg::StDiv: if (count_q == DivLast) state_d = sec_pkg::StIdle;
      sec_pkg::StMul: if (count_q == MulLast) state_d = sec_pkg::StEnv;
      sec_pkg::StEnv: state_d = sec_pkg::StSub;
      sec_pkg::StSub: state_d = sec_pkg::StLvl;
      sec_pkg::StLvl: if (count_q == LvlLast) state_d = sec_pkg::StFin;
      sec_pkg::StFin: if (out_load) state_d = sec_pkg::StIdle;
      default:        state_d = sec_pkg::StIdle;
    endcase
    count_d = (state_d != state_q) ? '0 : count_q + 1'b1;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q  <= sec_pkg::WindowLenRst;
      alpha_q <= sec_pkg::EnvAlphaRst;
      gain_q  <= sec_pkg::GainRst;
      talk_q  <= sec_pkg::TalkThrRst;
      clap_q  <= sec_pkg::ClapThrRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        sec_pkg::CfgWindowLen: wlen_q  <= cfg_wdata_i[4:0];
        sec_pkg::CfgEnvAlpha:  alpha_q <= cfg_wdata_i;
        sec_pkg::CfgGain:      gain_q  <= cfg_wdata_i[7:0];
        sec_pkg::CfgTalkThr:   talk_q  <= cfg_wdata_i;
        sec_pkg::CfgClapThr:   clap_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // control and block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sec_pkg::StIdle;
      count_q     <= '0;
      run_peak_q  <= '0;
      win_cnt_q   <= '0;
      calib_sum_q <= '0;
      win_calib_q <= '0;
      calib_q     <= 1'b1;
      base_q      <= '0;
      env_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (in_fire) begin
        if (win_done) begin
          run_peak_q <= '0;
          win_cnt_q  <= '0;
          if (calib_q) begin
            calib_sum_q <= sum_new;
            win_calib_q <= wc_new;
          end
        end else begin
          run_peak_q <= peak_new;
          win_cnt_q  <= cnt_new;
        end
      end
      if (state_q == sec_pkg::StDiv && count_q == DivLast) begin
        base_q  <= dq_d[EW-1:0];
        env_q   <= dq_d[EW-1:0];
        calib_q <= 1'b0;
      end
      if (state_q == sec_pkg::StEnv) begin
        env_q <= env_sum[EW-1:0];
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath payload
  always_ff @(posedge clk_i) begin
    if (in_fire && win_done) begin
      dq_q       <= {sum_new, {FW{1'b0}}};
      rem_q      <= '0;
      diff_q     <= diff_new;
      acc_q      <= '0;
      alpha_sh_q <= alpha_q;
      peak_q     <= peak_new;
    end
    if (state_q == sec_pkg::StDiv) begin
      dq_q  <= dq_d;
      rem_q <= rem_d;
    end
    if (state_q == sec_pkg::StMul) begin
      acc_q      <= acc_d;
      alpha_sh_q <= {1'b0, alpha_sh_q[15:1]};
    end
    if (state_q == sec_pkg::StSub) begin
      exc_q     <= (env_q > base_q) ? env_diff[EW-1:FW] : '0;
      gain_sh_q <= gain_q;
      prod_q    <= '0;
    end
    if (state_q == sec_pkg::StLvl) begin
      prod_q    <= prod_d;
      gain_sh_q <= {gain_sh_q[6:0], 1'b0};
    end
    if (out_load) begin
      class_q <= cls;
      level_q <= lvl_sat;
      opeak_q <= peak_q;
    end
  end

  assign in_ready_o    = in_ready;
  assign out_valid_o   = out_valid_q;
  assign sound_class_o = class_q;
  assign level_o       = level_q;
  assign window_peak_o = opeak_q;

`ifndef SYNTHESIS
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == sec_pkg::StFin))
    else $error("result appeared outside the final step");

  a_calib_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !calib_q |=> !calib_q)
    else $error("calibration restarted");

  a_mul_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sec_pkg::StMul) |-> (count_q <= MulLast))
    else $error("multiply step count overran");

  a_fin_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sec_pkg::StFin && out_valid_q && !out_ready_i)
      |=> (state_q == sec_pkg::StFin))
    else $error("pending result overwritten");

  a_no_result_calib: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && calib_q) |=> (state_q != sec_pkg::StMul))
    else $error("calibration window started a result");
`endif

endmodule
